// File: sv/hcd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds the parse state, outcome and status codes, the result record and the hex digit decoder.
// No dependencies; every other file of the block imports it.
package hcd_pkg;

    localparam int DEFAULT_SIZE_BITS  = 40;
    localparam int DEFAULT_COUNT_BITS = 48;
    localparam int BYTE_W             = 8;
    localparam int COUNT_OUT_W        = 48;
    localparam int STATUS_W           = 2;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CONSUMED = 2'd0,
        STAT_PAYLOAD  = 2'd1,
        STAT_FINISHED = 2'd2,
        STAT_ERROR    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PS_START  = 4'd0,
        PS_SIZE   = 4'd1,
        PS_EXT    = 4'd2,
        PS_LF1    = 4'd3,
        PS_DATA   = 4'd4,
        PS_CR2    = 4'd5,
        PS_LF2    = 4'd6,
        PS_TSTART = 4'd7,
        PS_TLINE  = 4'd8,
        PS_TLF1   = 4'd9,
        PS_TLF2   = 4'd10
    } t_parse_state;

    typedef enum logic [1:0] {
        OC_RUN  = 2'd0,
        OC_DONE = 2'd1,
        OC_ERR  = 2'd2
    } t_outcome;

    typedef struct packed {
        t_status                  status;
        logic [BYTE_W-1:0]        out_byte;
        logic [COUNT_OUT_W-1:0]   content_length;
        logic [COUNT_OUT_W-1:0]   bytes_consumed;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // Letters of either case have a low nibble of 1 to 6, which maps to 10 to 15.
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex r;
        r.valid = 1'b0;
        r.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.valid = 1'b1;
            r.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r.valid = 1'b1;
            r.value = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

// File: sv/hcd_in_if.sv
// Input channel of the chunked body decoder: one raw body byte per beat.
// Depends on hcd_pkg for the byte width.
interface hcd_in_if import hcd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: sv/hcd_out_if.sv
// Result channel of the chunked body decoder: one status record per beat.
// Depends on hcd_pkg for the field widths.
interface hcd_out_if import hcd_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [BYTE_W-1:0]      out_byte;
    logic [COUNT_OUT_W-1:0] content_length;
    logic [COUNT_OUT_W-1:0] bytes_consumed;

    modport source (output valid, output status, output out_byte, output content_length,
                    output bytes_consumed, input ready);
    modport sink   (input valid, input status, input out_byte, input content_length,
                    input bytes_consumed, output ready);
endinterface

// File: sv/http_chunked_decoder_unit.sv
// Top level of the HTTP chunked body decoder: input register, parser and result register.
// Depends on hcd_pkg, hcd_in_if, hcd_out_if, hcd_in_reg, hcd_parser and hcd_out_reg.
//
//   Port     Dir  Beat carries
//   i_in     in   in_byte: one raw byte of the chunked body
//   o_out    out  status, out_byte, content_length, bytes_consumed
//
// Every byte beat yields exactly one result beat, via the input and result registers.
// One byte per cycle is sustained while o_out.ready is high; state updates once per byte.
// Reset is synchronous and active low and returns the parser to the chunk start.
// A stalled result holds in the result register; i_in.ready drops only when both
// registers are full and o_out.ready is low.
module http_chunked_decoder_unit import hcd_pkg::*; #(
    parameter int SIZE_BITS  = DEFAULT_SIZE_BITS,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcd_in_if.sink    i_in,
    hcd_out_if.source o_out
);
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              advance;
    t_result           result;

    hcd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (advance),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    hcd_parser #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (byte_data),
        .o_result  (result)
    );

    hcd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (byte_valid),
        .i_result (result),
        .o_load   (advance),
        .o_out    (o_out)
    );
endmodule

// File: sv/hcd_in_reg.sv
// Input register of the chunked body decoder: captures one byte beat.
// Depends on hcd_pkg and hcd_in_if.
module hcd_in_reg import hcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcd_in_if.sink            i_in,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    // The register refills in the same cycle that its byte moves on.
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// File: sv/hcd_parser.sv
// Parse state machine of the chunked body decoder: state, counters and result of one byte.
// Depends on hcd_pkg.
module hcd_parser import hcd_pkg::*; #(
    parameter int SIZE_BITS  = DEFAULT_SIZE_BITS,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);
    localparam int SHIFT_W = SIZE_BITS + 4;

    t_parse_state           r_state, n_state;
    t_outcome               r_outcome, n_outcome;
    logic [SIZE_BITS-1:0]   r_rem, n_rem;
    logic [COUNT_BITS-1:0]  r_pay, n_pay;
    logic [COUNT_BITS-1:0]  r_inc, n_inc;

    t_hex                   hex;
    logic [SHIFT_W-1:0]     size_shift;
    logic [SIZE_BITS-1:0]   rem_dec;
    logic [COUNT_BITS-1:0]  pay_inc;
    logic [COUNT_BITS-1:0]  in_inc;
    t_parse_state           line_end_state;
    logic                   err;
    logic                   done;
    logic                   payload;
    logic [COUNT_BITS+COUNT_OUT_W-1:0] pay_ext;
    logic [COUNT_BITS+COUNT_OUT_W-1:0] inc_ext;

    assign hex            = hex_decode(i_byte);
    assign size_shift     = {r_rem, hex.value};
    assign rem_dec        = (r_rem != '0) ? r_rem - SIZE_BITS'(1) : r_rem;
    assign pay_inc        = (r_pay == '1) ? r_pay : r_pay + COUNT_BITS'(1);
    assign in_inc         = (r_inc == '1) ? r_inc : r_inc + COUNT_BITS'(1);
    assign line_end_state = (r_rem != '0) ? PS_DATA : PS_TSTART;

    always_comb begin
        n_state   = r_state;
        n_outcome = r_outcome;
        n_rem     = r_rem;
        n_pay     = r_pay;
        n_inc     = r_inc;
        err       = 1'b0;
        done      = 1'b0;
        payload   = 1'b0;
        if (r_outcome == OC_RUN) begin
            n_inc = in_inc;
            case (r_state)
                PS_START: begin
                    if (!hex.valid) begin
                        err = 1'b1;
                    end else begin
                        n_rem   = SIZE_BITS'(hex.value);
                        n_state = PS_SIZE;
                    end
                end
                PS_SIZE: begin
                    if (hex.valid) begin
                        // The size is already below the limit, so only the new top nibble
                        // can push it over.
                        n_rem = size_shift[SIZE_BITS-1:0];
                        err   = (size_shift[SHIFT_W-1:SIZE_BITS] != '0);
                    end else if (i_byte == CHAR_CR) begin
                        n_state = PS_LF1;
                    end else if (i_byte == CHAR_LF) begin
                        n_state = line_end_state;
                    end else begin
                        n_state = PS_EXT;
                    end
                end
                PS_EXT: begin
                    if (i_byte == CHAR_CR) begin
                        n_state = PS_LF1;
                    end else if (i_byte == CHAR_LF) begin
                        n_state = line_end_state;
                    end
                end
                PS_LF1: begin
                    if (i_byte == CHAR_LF) begin
                        n_state = line_end_state;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_DATA: begin
                    payload = 1'b1;
                    n_pay   = pay_inc;
                    n_rem   = rem_dec;
                    if (rem_dec == '0) begin
                        n_state = PS_CR2;
                    end
                end
                PS_CR2: begin
                    if (i_byte == CHAR_CR) begin
                        n_state = PS_LF2;
                    end else if (i_byte == CHAR_LF) begin
                        n_state = PS_START;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_LF2: begin
                    if (i_byte == CHAR_LF) begin
                        n_state = PS_START;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_TSTART: begin
                    if (i_byte == CHAR_CR) begin
                        n_state = PS_TLF2;
                    end else if (i_byte == CHAR_LF) begin
                        done = 1'b1;
                    end else begin
                        n_state = PS_TLINE;
                    end
                end
                PS_TLINE: begin
                    if (i_byte == CHAR_CR) begin
                        n_state = PS_TLF1;
                    end else if (i_byte == CHAR_LF) begin
                        n_state = PS_TSTART;
                    end
                end
                PS_TLF1: begin
                    if (i_byte == CHAR_LF) begin
                        n_state = PS_TSTART;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_TLF2: begin
                    if (i_byte == CHAR_LF) begin
                        done = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
            if (err) begin
                n_outcome = OC_ERR;
            end else if (done) begin
                n_outcome = OC_DONE;
            end
        end
    end

    // Counts reach the port zero-extended or cut to the port width.
    assign pay_ext = {{COUNT_OUT_W{1'b0}}, n_pay};
    assign inc_ext = {{COUNT_OUT_W{1'b0}}, n_inc};

    always_comb begin
        o_result = '0;
        if (n_outcome == OC_ERR) begin
            o_result.status = STAT_ERROR;
        end else if (n_outcome == OC_DONE) begin
            o_result.status         = STAT_FINISHED;
            o_result.content_length = pay_ext[COUNT_OUT_W-1:0];
            o_result.bytes_consumed = inc_ext[COUNT_OUT_W-1:0];
        end else if (payload) begin
            o_result.status   = STAT_PAYLOAD;
            o_result.out_byte = i_byte;
        end else begin
            o_result.status = STAT_CONSUMED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PS_START;
            r_outcome <= OC_RUN;
            r_rem     <= '0;
            r_pay     <= '0;
            r_inc     <= '0;
        end else if (i_advance) begin
            r_state   <= n_state;
            r_outcome <= n_outcome;
            r_rem     <= n_rem;
            r_pay     <= n_pay;
            r_inc     <= n_inc;
        end
    end
endmodule

// File: sv/hcd_out_reg.sv
// Result register of the chunked body decoder: holds one result beat until it is taken.
// Depends on hcd_pkg and hcd_out_if.
module hcd_out_reg import hcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_result  i_result,
    output logic     o_load,
    hcd_out_if.source o_out
);
    logic    r_valid;
    t_result r_result;
    logic    can_load;

    assign can_load = !r_valid || o_out.ready;
    assign o_load   = i_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_result.status;
    assign o_out.out_byte       = r_result.out_byte;
    assign o_out.content_length = r_result.content_length;
    assign o_out.bytes_consumed = r_result.bytes_consumed;
endmodule

// File: sv/hcd_checker.sv
// Port-level checks for the HTTP chunked body decoder, bound to the top level.
// Depends on hcd_pkg and http_chunked_decoder_unit.
module hcd_checker import hcd_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [STATUS_W-1:0]    i_status,
    input logic [BYTE_W-1:0]      i_out_byte,
    input logic [COUNT_OUT_W-1:0] i_content_length,
    input logic [COUNT_OUT_W-1:0] i_bytes_consumed
);
    logic                   r_seen_err;
    logic                   r_seen_done;
    logic [COUNT_OUT_W-1:0] r_len;
    logic [COUNT_OUT_W-1:0] r_cnt;
    logic                   out_beat;

    assign out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err  <= 1'b0;
            r_seen_done <= 1'b0;
        end else if (out_beat) begin
            if (i_status == STAT_ERROR) begin
                r_seen_err <= 1'b1;
            end
            if (i_status == STAT_FINISHED) begin
                r_seen_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat && i_status == STAT_FINISHED) begin
            r_len <= i_content_length;
            r_cnt <= i_bytes_consumed;
        end
    end

    // Once an error went out, every later result is an error.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_err |-> i_status == STAT_ERROR)
        else $error("result after an error is not an error");

    // Once the message finished, later results repeat the same counts.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_done |->
            i_status == STAT_FINISHED && i_content_length == r_len
            && i_bytes_consumed == r_cnt)
        else $error("result after finish changed");

    // Only a payload beat carries a byte, and only a finished beat carries counts.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STAT_FINISHED |->
            i_content_length == '0 && i_bytes_consumed == '0
            && (i_status == STAT_PAYLOAD || i_out_byte == '0))
        else $error("unused result field is not zero");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_out_byte)
            && $stable(i_content_length) && $stable(i_bytes_consumed))
        else $error("stalled result changed");
endmodule

bind http_chunked_decoder_unit hcd_checker u_hcd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_out_byte       (o_out.out_byte),
    .i_content_length (o_out.content_length),
    .i_bytes_consumed (o_out.bytes_consumed)
);

// File: verif/tb_http_chunked_decoder_unit.sv
// Self-checking testbench for http_chunked_decoder_unit: streams one chunked body and predicts
// every result beat with its own parser model. Depends on hcd_pkg, hcd_in_if and hcd_out_if.
module tb_http_chunked_decoder_unit import hcd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       CLK_PERIOD      = 4;
    localparam int       SIZE_LIMIT_BITS = DEFAULT_SIZE_BITS;
    localparam int       ITEM_TARGET     = 2000;
    localparam int       MAX_REPORTS     = 10;
    localparam longint   RUN_LIMIT_NS    = 4_000_000;

    // How the body stream is closed: a clean finish or one kind of malformed input.
    typedef enum int {
        END_FINISH,
        END_BAD_DIGIT,
        END_OVERFLOW,
        END_HDR_NO_LF,
        END_DATA_NO_EOL,
        END_DATA_NO_LF,
        END_TRAILER_NO_LF,
        END_EMPTY_NO_LF
    } t_ending;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcd_in_if  in_ch ();
    hcd_out_if out_ch ();

    http_chunked_decoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic [BYTE_W-1:0]      pending_bytes[$];
    t_result                expected_results[$];

    // Parser state mirrored from the block.
    t_parse_state           parse_st;
    logic [63:0]            chunk_left;
    logic [COUNT_OUT_W-1:0] payload_total;
    logic [COUNT_OUT_W-1:0] bytes_in;
    t_outcome               outcome;

    int gap_left;
    int stall_left;
    int source_calm;
    int sink_calm;
    int fail_count;

    function automatic int hex_value(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    // Mostly back-to-back beats, some short gaps, a few long ones, and now and then a calm run.
    function automatic int pick_idle(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] c);
        t_result r;
        int      h;
        bit      handled;
        bit      done;
        bit      err;
        r.status         = STAT_CONSUMED;
        r.out_byte       = '0;
        r.content_length = '0;
        r.bytes_consumed = '0;
        handled = 1'b0;
        done    = 1'b0;
        err     = 1'b0;
        if (outcome == OC_DONE) begin
            r.status         = STAT_FINISHED;
            r.content_length = payload_total;
            r.bytes_consumed = bytes_in;
        end else if (outcome == OC_ERR) begin
            r.status = STAT_ERROR;
        end else begin
            if (bytes_in != '1) bytes_in++;
            case (parse_st)
                PS_START: begin
                    h = hex_value(c);
                    if (h < 0) begin
                        err = 1'b1;
                    end else begin
                        chunk_left = 64'(h);
                        parse_st   = PS_SIZE;
                    end
                end
                PS_SIZE, PS_EXT, PS_LF1: begin
                    if (parse_st == PS_SIZE) begin
                        h = hex_value(c);
                        if (h >= 0) begin
                            chunk_left = {chunk_left[59:0], 4'(h)};
                            if (chunk_left >= (64'd1 << SIZE_LIMIT_BITS)) err = 1'b1;
                            handled = 1'b1;
                        end else begin
                            parse_st = PS_EXT;
                        end
                    end
                    // Extension bytes are skipped; a CR here must be followed by LF.
                    if (!handled && parse_st == PS_EXT) begin
                        if (c == CHAR_CR) begin
                            parse_st = PS_LF1;
                            handled  = 1'b1;
                        end else if (c != CHAR_LF) begin
                            handled = 1'b1;
                        end
                    end
                    if (!handled) begin
                        if (c != CHAR_LF) err = 1'b1;
                        else parse_st = (chunk_left != 0) ? PS_DATA : PS_TSTART;
                    end
                end
                PS_DATA: begin
                    if (payload_total != '1) payload_total++;
                    if (chunk_left != 0) chunk_left--;
                    if (chunk_left == 0) parse_st = PS_CR2;
                    r.status   = STAT_PAYLOAD;
                    r.out_byte = c;
                end
                PS_CR2: begin
                    if (c == CHAR_CR) parse_st = PS_LF2;
                    else if (c != CHAR_LF) err = 1'b1;
                    else parse_st = PS_START;
                end
                PS_LF2: begin
                    if (c != CHAR_LF) err = 1'b1;
                    else parse_st = PS_START;
                end
                PS_TSTART, PS_TLINE, PS_TLF1: begin
                    if (parse_st == PS_TSTART) begin
                        if (c == CHAR_CR) begin
                            parse_st = PS_TLF2;
                            handled  = 1'b1;
                        end else if (c == CHAR_LF) begin
                            done    = 1'b1;
                            handled = 1'b1;
                        end else begin
                            parse_st = PS_TLINE;
                        end
                    end
                    if (!handled && parse_st == PS_TLINE) begin
                        if (c == CHAR_CR) begin
                            parse_st = PS_TLF1;
                            handled  = 1'b1;
                        end else if (c != CHAR_LF) begin
                            handled = 1'b1;
                        end
                    end
                    if (!handled) begin
                        if (c != CHAR_LF) err = 1'b1;
                        else parse_st = PS_TSTART;
                    end
                end
                PS_TLF2: begin
                    if (c != CHAR_LF) err = 1'b1;
                    else done = 1'b1;
                end
                default: err = 1'b1;
            endcase
            if (err) begin
                outcome  = OC_ERR;
                r.status = STAT_ERROR;
            end else if (done) begin
                outcome          = OC_DONE;
                r.status         = STAT_FINISHED;
                r.content_length = payload_total;
                r.bytes_consumed = bytes_in;
            end
        end
        expected_results.push_back(r);
    endtask

    // ---------------- body stream construction ----------------

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] d);
        if (d < 10) return 8'h30 + 8'(d);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_byte(input bit allow_eol);
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom_range(0, 255));
        while (hex_value(b) >= 0 || (!allow_eol && (b == CHAR_CR || b == CHAR_LF)));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] not_lf_byte();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
        return b;
    endfunction

    task automatic push_eol();
        if ($urandom_range(0, 3) != 0) pending_bytes.push_back(CHAR_CR);
        pending_bytes.push_back(CHAR_LF);
    endtask

    task automatic push_size(input longint unsigned value);
        int nibs;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            pending_bytes.push_back(8'h30);
        nibs = 1;
        while (nibs < 16 && (value >> (4 * nibs)) != 0) nibs++;
        for (int i = nibs - 1; i >= 0; i--) pending_bytes.push_back(hex_char(4'(value >> (4 * i))));
    endtask

    task automatic push_ext();
        if ($urandom_range(0, 2) == 0) begin
            pending_bytes.push_back($urandom_range(0, 1) ? 8'h3B : non_hex_byte(1'b0));
            repeat ($urandom_range(0, 6)) pending_bytes.push_back(text_byte());
        end
    endtask

    task automatic push_head(input int n);
        push_size(longint'(n));
        push_ext();
        push_eol();
    endtask

    task automatic push_data(input int n);
        repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_trailer_line();
        pending_bytes.push_back(text_byte());
        repeat ($urandom_range(0, 10)) pending_bytes.push_back(text_byte());
        push_eol();
    endtask

    task automatic build_body();
        int      roll;
        int      n;
        t_ending ending;
        // Directed opening: CRLF and bare LF line ends, leading zero, extension,
        // extreme payload values, and CR and LF carried as payload.
        pending_bytes = {8'h31, CHAR_CR, CHAR_LF, 8'h00, CHAR_CR, CHAR_LF,
                         8'h30, 8'h31, 8'h3B, CHAR_LF, 8'hFF, CHAR_LF,
                         8'h32, 8'h20, 8'h78, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF,
                         CHAR_CR, CHAR_LF};
        while (pending_bytes.size() < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            n = (roll < 80) ? $urandom_range(1, 16) :
                (roll < 95) ? $urandom_range(17, 64) : $urandom_range(65, 300);
            push_head(n);
            push_data(n);
            push_eol();
        end
        roll   = $urandom_range(0, 13);
        ending = (roll < 7) ? END_FINISH : t_ending'(roll - 6);
        n      = $urandom_range(1, 16);
        case (ending)
            END_FINISH: begin
                push_head(0);
                repeat ($urandom_range(0, 3)) push_trailer_line();
                push_eol();
            end
            END_BAD_DIGIT: pending_bytes.push_back(non_hex_byte(1'b1));
            END_OVERFLOW: begin
                // Either exactly 2^40 or a random size that crosses it at the eleventh digit.
                if ($urandom_range(0, 1)) begin
                    pending_bytes.push_back(8'h31);
                    repeat (10) pending_bytes.push_back(8'h30);
                end else begin
                    pending_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
                    repeat (12) pending_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                end
            end
            END_HDR_NO_LF: begin
                push_size(longint'(n));
                push_ext();
                pending_bytes.push_back(CHAR_CR);
                pending_bytes.push_back(not_lf_byte());
            end
            END_DATA_NO_EOL: begin
                push_head(n);
                push_data(n);
                pending_bytes.push_back(text_byte());
            end
            END_DATA_NO_LF: begin
                push_head(n);
                push_data(n);
                pending_bytes.push_back(CHAR_CR);
                pending_bytes.push_back(not_lf_byte());
            end
            END_TRAILER_NO_LF: begin
                push_head(0);
                pending_bytes.push_back(text_byte());
                repeat ($urandom_range(0, 5)) pending_bytes.push_back(text_byte());
                pending_bytes.push_back(CHAR_CR);
                pending_bytes.push_back(not_lf_byte());
            end
            default: begin
                push_head(0);
                repeat ($urandom_range(0, 2)) push_trailer_line();
                pending_bytes.push_back(CHAR_CR);
                pending_bytes.push_back(not_lf_byte());
            end
        endcase
        // Bytes after the outcome is settled must all repeat it.
        repeat (20) pending_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) decode_byte(in_ch.in_byte);
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                in_ch.valid   <= 1'b1;
                in_ch.in_byte <= pending_bytes.pop_front();
                gap_left = pick_idle(source_calm);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected: status %0d", $realtime,
                                 out_ch.status);
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.status !== want.status || out_ch.out_byte !== want.out_byte ||
                        out_ch.content_length !== want.content_length ||
                        out_ch.bytes_consumed !== want.bytes_consumed) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp st=%0d byte=%02h len=%0d cnt=%0d",
                                     $realtime, want.status, want.out_byte,
                                     want.content_length, want.bytes_consumed);
                            $display("%0t:          got st=%0d byte=%02h len=%0d cnt=%0d",
                                     $realtime, out_ch.status, out_ch.out_byte,
                                     out_ch.content_length, out_ch.bytes_consumed);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_idle(sink_calm);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        parse_st      = PS_START;
        chunk_left    = '0;
        payload_total = '0;
        bytes_in      = '0;
        outcome       = OC_RUN;
        source_calm   = 0;
        sink_calm     = 0;
        fail_count    = 0;
        build_body();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
